// ===== rtl/core/mpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mpq_pkg: shared definitions for the min-priority queue
// Operation and status codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
package mpq_pkg;

  // Default sizes for the top-level parameters.
  localparam int CAPACITY_DEF      = 16;
  localparam int VALUE_BITS_DEF    = 32;
  localparam int PRIORITY_BITS_DEF = 16;

  // Field widths fixed by the interface.
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;

  // Operation codes carried by one input beat.
  typedef logic [KIND_W-1:0] kind_t;
  localparam kind_t KIND_PUSH = 2'd0;
  localparam kind_t KIND_POP  = 2'd1;
  localparam kind_t KIND_PEEK = 2'd2;

  // Result status codes.
  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_SHIFT,
    S_FINISH
  } state_t;

endpackage

// ===== rtl/core/mpq_store.sv =====
// ----------------------------------------------------------------------------
// mpq_store: entry memory of the min-priority queue
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mpq_store #(
  parameter int DEPTH         = 16,
  parameter int VALUE_BITS    = 32,
  parameter int PRIORITY_BITS = 16,
  localparam int IDX_W        = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [IDX_W-1:0]         wr_addr,
  input  logic [VALUE_BITS-1:0]    wr_value,
  input  logic [PRIORITY_BITS-1:0] wr_priority,
  input  logic [IDX_W-1:0]         rd_addr,
  output logic [VALUE_BITS-1:0]    rd_value,
  output logic [PRIORITY_BITS-1:0] rd_priority
);

  logic [VALUE_BITS-1:0]    mem_value_r    [DEPTH];
  logic [PRIORITY_BITS-1:0] mem_priority_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_value_r[wr_addr]    <= wr_value;
      mem_priority_r[wr_addr] <= wr_priority;
    end
  end

  // Read port; data is registered and appears in the cycle after the address.
  always_ff @(posedge clk) begin
    rd_value    <= mem_value_r[rd_addr];
    rd_priority <= mem_priority_r[rd_addr];
  end

endmodule

// ===== rtl/core/min_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// min_priority_queue_top: bounded min-priority queue over an unsorted store
// Usage:
//   Input beats (in_valid/in_ready) carry an operation: push, pop or peek.
//   Every input beat produces exactly one result beat (out_valid/out_ready)
//   with the chosen value, a status and a flag for an empty queue.
//   Entries sit in arrival order in a one-port-read, one-port-write memory.
//   A push or an unknown code goes from dispatch straight to its result.
//   A peek on N entries scans them all: one shared signed
//   comparator checks one entry per cycle as the memory streams them out.
//   A pop then moves each entry behind the winner down by one slot
//   through the same memory port.
//   Pop or peek on an empty queue skips the scan.
//   One operation is in flight at a time; in_ready is high only while the
//   sequencer is idle. The result register lets the next operation be
//   accepted while an earlier result still waits for the receiver.
//   If the receiver stalls, a finished result is held until it is taken.
//   Reset empties the queue; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
module min_priority_queue_top #(
  parameter int CAPACITY      = mpq_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS    = mpq_pkg::VALUE_BITS_DEF,
  parameter int PRIORITY_BITS = mpq_pkg::PRIORITY_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  mpq_pkg::kind_t               in_kind,
  input  logic [VALUE_BITS-1:0]        in_item_value,
  input  logic signed [PRIORITY_BITS-1:0] in_item_priority,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [VALUE_BITS-1:0]        out_value,
  output mpq_pkg::status_t             out_status,
  output logic                         out_now_empty
);

  import mpq_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Sequencer and operation registers.
  state_t                   state_r, state_nxt;
  kind_t                    kind_r, kind_nxt;
  logic [VALUE_BITS-1:0]    val_r, val_nxt;
  logic [PRIORITY_BITS-1:0] pri_r, pri_nxt;
  status_t                  status_r, status_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;

  // Scan and shift pointers.
  logic [CNT_W-1:0]         idx_r, idx_nxt;
  logic                     rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]         rd_idx_r, rd_idx_nxt;

  // Best entry found so far.
  logic [IDX_W-1:0]         best_idx_r, best_idx_nxt;
  logic [PRIORITY_BITS-1:0] best_pri_r, best_pri_nxt;
  logic [VALUE_BITS-1:0]    best_val_r, best_val_nxt;

  // Result register.
  logic                     out_valid_r, out_valid_nxt;
  logic [VALUE_BITS-1:0]    out_value_r, out_value_nxt;
  status_t                  out_status_r, out_status_nxt;
  logic                     out_empty_r, out_empty_nxt;

  // Memory port signals.
  logic                     wr_en;
  logic [IDX_W-1:0]         wr_addr;
  logic [VALUE_BITS-1:0]    wr_value;
  logic [PRIORITY_BITS-1:0] wr_priority;
  logic [IDX_W-1:0]         rd_addr;
  logic [VALUE_BITS-1:0]    rd_value;
  logic [PRIORITY_BITS-1:0] rd_priority;

  // Shared decode.
  logic                     in_fire;
  logic                     is_full;
  logic                     is_empty;
  logic                     issue;
  logic [CNT_W-1:0]         cnt_m1;
  logic                     last_beat;
  logic                     take_new;
  logic [IDX_W-1:0]         win_idx;
  logic                     need_shift;
  logic                     out_free;

  mpq_store #(
    .DEPTH         (CAPACITY),
    .VALUE_BITS    (VALUE_BITS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_store (
    .clk         (clk),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_value    (wr_value),
    .wr_priority (wr_priority),
    .rd_addr     (rd_addr),
    .rd_value    (rd_value),
    .rd_priority (rd_priority)
  );

  // Status of the store and of the read stream.
  always_comb begin
    in_fire    = in_valid && in_ready;
    is_full    = (count_r == CNT_W'(CAPACITY));
    is_empty   = (count_r == '0);
    issue      = (idx_r < count_r);
    cnt_m1     = count_r - CNT_W'(1);
    last_beat  = rd_vld_r && (CNT_W'(rd_idx_r) == cnt_m1);
    take_new   = rd_vld_r && ((rd_idx_r == '0) ||
                 ($signed(rd_priority) < $signed(best_pri_r)));
    win_idx    = take_new ? rd_idx_r : best_idx_r;
    need_shift = (CNT_W'(win_idx) != cnt_m1);
    out_free   = !out_valid_r || out_ready;
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (((kind_r == KIND_POP) || (kind_r == KIND_PEEK)) && !is_empty) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_SCAN: begin
        if (last_beat) begin
          if ((kind_r == KIND_POP) && need_shift) state_nxt = S_SHIFT;
          else state_nxt = S_FINISH;
        end
      end
      S_SHIFT: begin
        if (last_beat) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath control for each state.
  always_comb begin
    in_ready       = (state_r == S_IDLE);
    kind_nxt       = kind_r;
    val_nxt        = val_r;
    pri_nxt        = pri_r;
    status_nxt     = status_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    rd_vld_nxt     = 1'b0;
    rd_idx_nxt     = idx_r[IDX_W-1:0];
    best_idx_nxt   = best_idx_r;
    best_pri_nxt   = best_pri_r;
    best_val_nxt   = best_val_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_empty_nxt  = out_empty_r;
    wr_en          = 1'b0;
    wr_addr        = count_r[IDX_W-1:0];
    wr_value       = val_r;
    wr_priority    = pri_r;
    rd_addr        = idx_r[IDX_W-1:0];

    case (state_r)
      // Capture the operation of an accepted beat.
      S_IDLE: begin
        if (in_fire) begin
          kind_nxt = in_kind;
          val_nxt  = in_item_value;
          pri_nxt  = in_item_priority;
        end
      end
      // Write a push into the store; set up the scan for pop and peek.
      S_DISPATCH: begin
        status_nxt   = ST_OK;
        best_val_nxt = '0;
        idx_nxt      = '0;
        case (kind_r)
          KIND_PUSH: begin
            if (is_full) begin
              status_nxt = ST_FULL;
            end else begin
              wr_en     = 1'b1;
              count_nxt = count_r + CNT_W'(1);
            end
          end
          KIND_POP, KIND_PEEK: begin
            if (is_empty) status_nxt = ST_EMPTY;
          end
          default: begin
          end
        endcase
      end
      // Stream entries out in arrival order; a strict compare keeps the
      // earliest of equal priorities.
      S_SCAN: begin
        rd_vld_nxt = issue;
        if (issue) idx_nxt = idx_r + CNT_W'(1);
        if (take_new) begin
          best_idx_nxt = rd_idx_r;
          best_pri_nxt = rd_priority;
          best_val_nxt = rd_value;
        end
        if (last_beat) begin
          idx_nxt = CNT_W'(win_idx) + CNT_W'(1);
          if ((kind_r == KIND_POP) && !need_shift) count_nxt = cnt_m1;
        end
      end
      // Move every entry behind the removed one down by one slot.
      S_SHIFT: begin
        rd_vld_nxt  = issue;
        if (issue) idx_nxt = idx_r + CNT_W'(1);
        wr_en       = rd_vld_r;
        wr_addr     = rd_idx_r - IDX_W'(1);
        wr_value    = rd_value;
        wr_priority = rd_priority;
        if (last_beat) count_nxt = cnt_m1;
      end
      // Load the result register once it is free.
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = best_val_r;
          out_status_nxt = status_r;
          out_empty_nxt  = is_empty;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    val_r        <= val_nxt;
    pri_r        <= pri_nxt;
    status_r     <= status_nxt;
    idx_r        <= idx_nxt;
    rd_idx_r     <= rd_idx_nxt;
    best_idx_r   <= best_idx_nxt;
    best_pri_r   <= best_pri_nxt;
    best_val_r   <= best_val_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_empty_r  <= out_empty_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_status    = out_status_r;
  assign out_now_empty = out_empty_r;

  // The entry count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  // A full report only goes out while the store is full.
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && status_r == ST_FULL) |-> is_full)
    else $error("full status with free slots");

  // An empty report always comes with the empty flag.
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_EMPTY) |-> out_empty_r)
    else $error("empty status without empty flag");

  // Every returned memory word lies below the entry count.
  a_read_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (CNT_W'(rd_idx_r) < count_r))
    else $error("read beyond stored entries");

endmodule
